// File: sv/aodv_rte_pkg.sv
`timescale 1ns / 1ps

package aodv_rte_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DST_W       = 8;
  localparam int FIELD_W     = 8;
  localparam logic [DST_W:0] DEPTH_EXT = (DST_W + 1)'(TABLE_DEPTH);

  localparam int OPQ_DEPTH   = 2;
  localparam int OPQ_PTR_W   = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);

  localparam int RESQ_DEPTH  = 2;
  localparam int RESQ_PTR_W  = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_UPDATE     = 3'd0,
    CMD_LOOKUP     = 3'd1,
    CMD_FRESH      = 3'd2,
    CMD_STALE      = 3'd3,
    CMD_INVALIDATE = 3'd4,
    CMD_INIT       = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_UPDATE,
    OP_LOOKUP,
    OP_FRESH,
    OP_STALE,
    OP_INVAL,
    OP_INIT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  idx;
    logic [FIELD_W-1:0] via;
    logic [FIELD_W-1:0] hops;
    logic [FIELD_W-1:0] seq;
    logic               known;
    logic               prev_match;
    logic               own_match;
  } item_t;

  typedef struct packed {
    logic               known;
    logic [FIELD_W-1:0] hop_addr;
    logic [FIELD_W-1:0] hops;
    logic [FIELD_W-1:0] seq;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] hop_addr;
    logic [FIELD_W-1:0] hops;
    logic [FIELD_W-1:0] seq;
    logic               known;
    logic               rerr;
    logic [FIELD_W-1:0] rerr_seq;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

// File: sv/aodv_rte_front.sv
`timescale 1ns / 1ps

module aodv_rte_front import aodv_rte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [DST_W-1:0]   cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_command,
  input  logic [DST_W-1:0]   in_destination,
  input  logic [FIELD_W-1:0] in_via_hop,
  input  logic [FIELD_W-1:0] in_hop_distance,
  input  logic [FIELD_W-1:0] in_sequence_req,
  input  logic               in_sequence_known,
  input  logic [DST_W-1:0]   in_previous_hop,
  output logic [DST_W-1:0]   self_addr,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  logic [DST_W-1:0]     self_addr_r;
  item_t                q_r [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_r;
  logic [OPQ_PTR_W-1:0] rd_ptr_r;
  logic [OPQ_CNT_W-1:0] count_r;
  logic [OPQ_PTR_W-1:0] wr_ptr_nxt;
  logic [OPQ_PTR_W-1:0] rd_ptr_nxt;
  logic [OPQ_CNT_W-1:0] count_nxt;
  logic                 push;
  logic                 pop;
  logic                 inrange;
  item_t                item_nxt;

  assign self_addr   = self_addr_r;
  assign in_full     = (count_r == OPQ_CNT_W'(OPQ_DEPTH));
  assign q_valid     = (count_r != '0);
  assign q_item      = q_r[rd_ptr_r];
  assign push        = in_push && !in_full;
  assign pop         = q_pop && q_valid;
  assign inrange     = ({1'b0, in_destination} < DEPTH_EXT);

  // classify the transaction before it enters the queue
  always_comb begin
    item_nxt            = '0;
    item_nxt.idx        = in_destination[ADDR_W-1:0];
    item_nxt.via        = in_via_hop;
    item_nxt.hops       = in_hop_distance;
    item_nxt.seq        = in_sequence_req;
    item_nxt.known      = in_sequence_known;
    item_nxt.prev_match = (in_destination == in_previous_hop);
    item_nxt.own_match  = inrange && (in_destination == self_addr_r);
    case (in_command)
      CMD_UPDATE:     item_nxt.op = inrange ? OP_UPDATE : OP_NOP;
      CMD_LOOKUP:     item_nxt.op = inrange ? OP_LOOKUP : OP_NOP;
      CMD_FRESH:      item_nxt.op = inrange ? OP_FRESH  : OP_NOP;
      CMD_STALE:      item_nxt.op = inrange ? OP_STALE  : OP_NOP;
      CMD_INVALIDATE: item_nxt.op = inrange ? OP_INVAL  : OP_NOP;
      CMD_INIT:       item_nxt.op = OP_INIT;
      default:        item_nxt.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + OPQ_CNT_W'(push) - OPQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_addr_r <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        self_addr_r <= cfg_wdata;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_nxt;
    end
  end

endmodule

// File: sv/aodv_rte_back.sv
`timescale 1ns / 1ps

module aodv_rte_back import aodv_rte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DST_W-1:0]      self_addr,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  input  logic [RESQ_CNT_W-1:0] res_used,
  input  logic                  res_pop,
  output logic                  res_push,
  output result_t               res_data
);

  bk_state_t            state_r;
  bk_state_t            state_nxt;
  item_t                item_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;
  entry_t               table_mem [TABLE_DEPTH];
  entry_t               rd_data_r;
  logic                 fwd_r;
  entry_t               fwd_data_r;

  logic                 exec;
  logic                 issue;
  logic [RESQ_CNT_W:0]  credit;
  entry_t               ent;
  logic                 v;
  logic                 own_in;
  logic [ADDR_W-1:0]    own_idx;
  logic [FIELD_W-1:0]   up_diff;
  logic [FIELD_W-1:0]   fresh_diff;
  logic [FIELD_W-1:0]   inc_seq;
  logic                 take;
  logic                 stale_rm;
  logic                 inval_rm;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  entry_t               mem_wdata;

  // result slots in use or claimed by the item being executed, less the slot being popped
  assign credit = {1'b0, res_used} + (RESQ_CNT_W + 1)'(exec) - (RESQ_CNT_W + 1)'(res_pop);
  assign issue  = q_valid && (credit < (RESQ_CNT_W + 1)'(RESQ_DEPTH));

  always_comb begin
    state_nxt = issue ? BK_EXEC : BK_IDLE;
  end

  always_comb begin
    exec     = (state_r == BK_EXEC);
    q_pop    = issue;
    res_push = exec;
  end

  assign ent        = fwd_r ? fwd_data_r : rd_data_r;
  assign v          = valid_r[item_r.idx];
  assign own_in     = ({1'b0, self_addr} < DEPTH_EXT);
  assign own_idx    = self_addr[ADDR_W-1:0];
  assign up_diff    = item_r.seq - ent.seq;
  assign fresh_diff = ent.seq - item_r.seq;
  assign inc_seq    = ent.seq + 1'b1;
  assign take       = !v || !ent.known || ((up_diff != '0) && !up_diff[FIELD_W-1]) ||
                      ((up_diff == '0) && (item_r.hops < ent.hops));
  assign stale_rm   = !item_r.prev_match && v && ent.known && (item_r.seq > ent.seq);
  assign inval_rm   = !item_r.prev_match && v && ent.known && (inc_seq > ent.seq);

  always_comb begin
    res_data  = '0;
    mem_we    = 1'b0;
    mem_waddr = item_r.idx;
    mem_wdata = ent;
    valid_nxt = valid_r;
    if (exec) begin
      case (item_r.op)
        OP_UPDATE: begin
          if (take) begin
            mem_we             = 1'b1;
            mem_wdata.known    = item_r.known;
            mem_wdata.hop_addr = item_r.via;
            mem_wdata.hops     = item_r.hops;
            mem_wdata.seq      = item_r.seq;
            valid_nxt[item_r.idx] = 1'b1;
            res_data.hit   = 1'b1;
            res_data.hops  = item_r.hops;
            res_data.seq   = item_r.seq;
            res_data.known = item_r.known;
          end else if (v) begin
            res_data.hops  = ent.hops;
            res_data.seq   = ent.seq;
            res_data.known = ent.known;
          end
        end
        OP_LOOKUP: begin
          if (v) begin
            res_data.hops  = ent.hops;
            res_data.seq   = ent.seq;
            res_data.known = ent.known;
            if (!item_r.own_match) begin
              res_data.hit      = 1'b1;
              res_data.hop_addr = ent.hop_addr;
            end
          end
        end
        OP_FRESH: begin
          if (v) begin
            res_data.hops  = ent.hops;
            res_data.seq   = ent.seq;
            res_data.known = ent.known;
          end
          res_data.hit = v && ent.known && !fresh_diff[FIELD_W-1];
        end
        OP_STALE: begin
          if (stale_rm) begin
            valid_nxt[item_r.idx] = 1'b0;
            res_data.hit = 1'b1;
          end else if (v) begin
            res_data.hops  = ent.hops;
            res_data.seq   = ent.seq;
            res_data.known = ent.known;
          end
        end
        OP_INVAL: begin
          valid_nxt[item_r.idx] = 1'b0;
          res_data.hit      = v;
          res_data.rerr     = inval_rm;
          res_data.rerr_seq = inval_rm ? inc_seq : '0;
        end
        OP_INIT: begin
          valid_nxt    = '0;
          res_data.hit = 1'b1;
          if (own_in) begin
            valid_nxt[own_idx] = 1'b1;
            mem_we             = 1'b1;
            mem_waddr          = own_idx;
            mem_wdata.known    = 1'b1;
            mem_wdata.hop_addr = self_addr;
            mem_wdata.hops     = '0;
            mem_wdata.seq      = '0;
          end
          if (item_r.own_match) begin
            res_data.known = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (issue) begin
        fwd_r <= mem_we && (mem_waddr == q_item.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      item_r     <= q_item;
      fwd_data_r <= mem_wdata;
    end
  end

  // route table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= table_mem[q_item.idx];
    end
  end

endmodule

// File: sv/aodv_rte_resq.sv
`timescale 1ns / 1ps

module aodv_rte_resq import aodv_rte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop,
  output logic                  empty,
  output result_t               head,
  output logic [RESQ_CNT_W-1:0] used
);

  result_t               q_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_r;
  logic [RESQ_PTR_W-1:0] rd_ptr_r;
  logic [RESQ_CNT_W-1:0] count_r;
  logic [RESQ_PTR_W-1:0] wr_ptr_nxt;
  logic [RESQ_PTR_W-1:0] rd_ptr_nxt;
  logic [RESQ_CNT_W-1:0] count_nxt;
  logic                  do_pop;

  assign empty  = (count_r == '0);
  assign head   = q_r[rd_ptr_r];
  assign used   = count_r;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + RESQ_CNT_W'(push) - RESQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/aodv_route_table_engine_top.sv
`timescale 1ns / 1ps

// AODV route table, one entry per destination address, one command per transaction
// (update, lookup, freshness check, stale removal, invalidate, init). A transaction
// waits in a two-deep command queue; the back end then reads the table memory as
// it issues the transaction, evaluates and writes back in its execute state, and
// pushes the result into the result queue, whose head drives the out_ ports. Back to
// back transactions overlap, so the table sustains one transaction per cycle while
// results are being popped; a write followed by a read of the same entry is
// forwarded. Valid bits are flip-flops cleared by reset and by init, which then marks
// the own address's entry valid, so the table is usable straight after reset with no
// clearing pass. Write cfg_wdata (own address) only while no transaction is outstanding.
module aodv_route_table_engine_top import aodv_rte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [DST_W-1:0]   cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_command,
  input  logic [DST_W-1:0]   in_destination,
  input  logic [FIELD_W-1:0] in_via_hop,
  input  logic [FIELD_W-1:0] in_hop_distance,
  input  logic [FIELD_W-1:0] in_sequence_req,
  input  logic               in_sequence_known,
  input  logic [DST_W-1:0]   in_previous_hop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_hit,
  output logic [FIELD_W-1:0] out_next_hop_out,
  output logic [FIELD_W-1:0] out_stored_hops,
  output logic [FIELD_W-1:0] out_stored_sequence,
  output logic               out_stored_known,
  output logic               out_rerr_needed,
  output logic [FIELD_W-1:0] out_rerr_sequence
);

  logic [DST_W-1:0]      self_addr;
  logic                  q_valid;
  item_t                 q_item;
  logic                  q_pop;
  logic [RESQ_CNT_W-1:0] res_used;
  logic                  res_pop;
  logic                  res_push;
  result_t               res_data;
  result_t               head;

  assign res_pop = out_pop && !out_empty;

  aodv_rte_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_destination    (in_destination),
    .in_via_hop        (in_via_hop),
    .in_hop_distance   (in_hop_distance),
    .in_sequence_req   (in_sequence_req),
    .in_sequence_known (in_sequence_known),
    .in_previous_hop   (in_previous_hop),
    .self_addr         (self_addr),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  aodv_rte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .self_addr   (self_addr),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_used    (res_used),
    .res_pop     (res_pop),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  aodv_rte_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (head),
    .used      (res_used)
  );

  assign out_hit             = head.hit;
  assign out_next_hop_out    = head.hop_addr;
  assign out_stored_hops     = head.hops;
  assign out_stored_sequence = head.seq;
  assign out_stored_known    = head.known;
  assign out_rerr_needed     = head.rerr;
  assign out_rerr_sequence   = head.rerr_seq;

endmodule
